// ===== src/hbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants for the histogram box smoother: request and
// result payloads, register indexes, reset values and controller states.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int VALUE_W    = 8;
    localparam int RESULT_W   = 21;
    localparam int LEVELS_W   = 9;
    localparam int WINDOW_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    // bin index wide enough for value plus half window
    localparam int IDX_W      = 9;

    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 9'd256;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] value;
    } hbs_in_t;

    typedef struct packed {
        logic [RESULT_W-1:0] bin_count;
        logic [RESULT_W-1:0] smoothed_count;
        logic                index_invalid;
        logic                dropped_seen;
    } hbs_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DIVIDE,
        ST_DONE
    } hbs_state_t;

endpackage
`default_nettype wire

// ===== src/histogram_box_smoother.sv =====
`default_nettype none
// add requests: one per cycle while idle (s_ready), no result; registered read, then write
// query requests: one at a time, answer after span reads lo..hi (clipped), drain,
//   divide and output, or straight to output for an invalid index; a held-off
//   output stalls the next request until the answer moves on
// reset: synchronous active-low; a clearing pass over all MAX_LEVELS bins zeroes
//   the bin memory, with no requests taken until it ends
// ----------------------------------------------------------------------------
// histogram_box_smoother
// Grey-level histogram in a single-port-write, one-read memory, with
// saturating counts and a box-smoothed query path.
// ----------------------------------------------------------------------------
module histogram_box_smoother #(
    parameter int MAX_LEVELS = 256,
    parameter int MAX_WINDOW = 31,
    parameter int MAX_PIXELS = 1048576
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [hbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hbs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire hbs_pkg::hbs_in_t                   s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output hbs_pkg::hbs_out_t                       m_data
);
    import hbs_pkg::*;

    localparam int AW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W = CNT_W + WINDOW_W;
    localparam int NUM_W = SUM_W + 1;
    localparam int DEN_W = WINDOW_W + 1;

    // configuration
    logic [LEVELS_W-1:0] levels_reg;
    logic [WINDOW_W-1:0] window_reg;
    logic [LEVELS_W-1:0] eff_lv;
    logic [WINDOW_W-1:0] eff_win;
    logic [WINDOW_W-1:0] half;

    // control
    hbs_state_t state_reg, state_next;
    logic [AW-1:0] clr_idx_reg;
    logic          dropped_reg;

    // request decode
    logic             accept;
    logic [IDX_W-1:0] in_idx;
    logic             in_ok;
    logic             add_go;
    logic             drop_go;
    logic             query_go;
    logic [IDX_W-1:0] lo_idx;
    logic [IDX_W-1:0] hi_idx;
    logic [IDX_W-1:0] top_idx;

    // memory
    logic [CNT_W-1:0] mem [MAX_LEVELS];
    logic [CNT_W-1:0] mem_rd_reg;
    logic [AW-1:0]    mem_raddr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [CNT_W-1:0] mem_wdata;

    // add pipeline
    logic             s1_valid_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             wr_valid_reg;
    logic [AW-1:0]    wr_addr_reg;
    logic [CNT_W-1:0] wr_data_reg;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] sat_cnt;

    // query path
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] hi_reg;
    logic [IDX_W-1:0] qidx_reg;
    logic             rsp_valid_reg;
    logic [IDX_W-1:0] rsp_idx_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] bin_reg;
    logic [CNT_W-1:0] bin_next;
    hbs_out_t         res_reg;
    logic             out_free;

    // divider
    logic             div_start;
    logic [NUM_W-1:0] div_numer;
    logic [DEN_W-1:0] div_denom;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;

    // output register
    logic     m_valid_reg;
    hbs_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= LEVELS_RESET;
            window_reg <= WINDOW_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LEVELS: levels_reg <= cfg_wdata[LEVELS_W-1:0];
                CFG_WINDOW: window_reg <= cfg_wdata[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_lv = (32'(levels_reg) > MAX_LEVELS) ? LEVELS_W'(MAX_LEVELS) : levels_reg;
        if (window_reg == '0) begin
            eff_win = WINDOW_W'(1);
        end else if (32'(window_reg) > MAX_WINDOW) begin
            eff_win = WINDOW_W'(MAX_WINDOW);
        end else begin
            eff_win = window_reg;
        end
        half = (eff_win - 1'b1) >> 1;
    end

    assign accept   = s_valid && s_ready;
    assign in_idx   = IDX_W'(s_data.value);
    assign in_ok    = in_idx < eff_lv;
    assign add_go   = accept && (s_data.operation == OP_ADD) && in_ok;
    assign drop_go  = accept && (s_data.operation == OP_ADD) && !in_ok;
    assign query_go = accept && (s_data.operation == OP_QUERY);

    // window bounds clipped to the bins in use
    always_comb begin
        lo_idx  = (in_idx >= IDX_W'(half)) ? in_idx - IDX_W'(half) : '0;
        top_idx = eff_lv - 1'b1;
        hi_idx  = in_idx + IDX_W'(half);
        if (hi_idx > top_idx) begin
            hi_idx = top_idx;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == AW'(MAX_LEVELS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (query_go) begin
                    state_next = in_ok ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                if (rd_idx_reg == hi_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_DRAIN);
        mem_raddr = (state_reg == ST_READ) ? AW'(rd_idx_reg) : AW'(in_idx);
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_valid_reg;
            mem_waddr = s1_addr_reg;
            mem_wdata = sat_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (drop_go) begin
                dropped_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rd_reg <= mem[mem_raddr];
    end

    // a write landing on the same edge as the read is not seen by the read
    assign cur_cnt = (wr_valid_reg && (wr_addr_reg == s1_addr_reg)) ? wr_data_reg
                                                                    : mem_rd_reg;
    assign sat_cnt = (cur_cnt < CNT_W'(MAX_PIXELS)) ? cur_cnt + 1'b1 : cur_cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= add_go;
            wr_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_addr_reg <= AW'(in_idx);
        wr_addr_reg <= s1_addr_reg;
        wr_data_reg <= sat_cnt;
    end

    assign sum_next = sum_reg + (rsp_valid_reg ? SUM_W'(mem_rd_reg) : '0);
    assign bin_next = (rsp_valid_reg && (rsp_idx_reg == qidx_reg)) ? mem_rd_reg : bin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_valid_reg <= 1'b0;
        end else begin
            rsp_valid_reg <= (state_reg == ST_READ);
        end
    end

    always_ff @(posedge aclk) begin
        rsp_idx_reg <= rd_idx_reg;
        if (query_go) begin
            rd_idx_reg <= lo_idx;
            hi_reg     <= hi_idx;
            qidx_reg   <= in_idx;
            sum_reg    <= '0;
            bin_reg    <= '0;
        end else begin
            if (state_reg == ST_READ) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            sum_reg <= sum_next;
            bin_reg <= bin_next;
        end
        if (query_go && !in_ok) begin
            res_reg <= '{bin_count: '0, smoothed_count: '0,
                         index_invalid: 1'b1, dropped_seen: dropped_reg};
        end else if ((state_reg == ST_DIVIDE) && div_done) begin
            res_reg <= '{bin_count: RESULT_W'(bin_reg),
                         smoothed_count: RESULT_W'(div_quot),
                         index_invalid: 1'b0, dropped_seen: dropped_reg};
        end
    end

    // rounded quotient: (2*sum + W) / (2*W)
    assign div_numer = {sum_next, 1'b0} + NUM_W'(eff_win);
    assign div_denom = {eff_win, 1'b0};

    hbs_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== src/hbs_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_div
// Restoring divider, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle when the quotient is valid.
// ----------------------------------------------------------------------------
module hbs_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    output logic                  done,
    output logic [NUM_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;

    logic [DEN_W:0]    trial;
    logic              fits;
    logic [DEN_W:0]    diff;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // numerator shifts out the top while quotient bits shift in below
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire
